// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Widths, length codes and the phase type shared by the deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int BYTE_W    = 8;
  localparam int OPCODE_W  = 4;
  localparam int LEN_W     = 64;
  localparam int KEY_W     = 32;
  localparam int HCOUNT_W  = 4;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Number of extended length bytes for each form.
  localparam logic [HCOUNT_W-1:0] EXT_BYTES_NONE = 4'd0;
  localparam logic [HCOUNT_W-1:0] EXT_BYTES_16   = 4'd2;
  localparam logic [HCOUNT_W-1:0] EXT_BYTES_64   = 4'd8;

  // Fixed header bytes and mask key bytes.
  localparam logic [HCOUNT_W-1:0] BASE_HDR_BYTES = 4'd2;
  localparam logic [HCOUNT_W-1:0] KEY_BYTES      = 4'd4;

  // Header byte positions with a register of their own.
  localparam logic [HCOUNT_W-1:0] POS_FIRST  = 4'd0;
  localparam logic [HCOUNT_W-1:0] POS_SECOND = 4'd1;

  // Kind of a result transaction.
  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  // Receive phase.
  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/wsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer byte channel
// Valid/ready channel that carries one received stream byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_byte_if;
  import wsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ===== hdl/wsd_result_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer result channel
// Valid/ready channel that carries one header or payload result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_result_if;
  import wsd_pkg::*;

  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [BYTE_W-1:0]   payload_byte;
  logic [OPCODE_W-1:0] frame_opcode;
  logic                final_fragment;
  logic                was_masked;
  logic [LEN_W-1:0]    frame_length;
  logic                last_of_frame;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_opcode, output final_fragment, output was_masked,
                  output frame_length, output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_opcode, input final_fragment, input was_masked,
                  input frame_length, input last_of_frame, output ready);

endinterface

`default_nettype wire

// ===== hdl/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a received byte stream and unmasks the payload.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock and gives at most one result
// transaction per byte, the cycle after the byte is taken. A frame header of
// 2 to 14 bytes yields a single header result when its last byte arrives;
// earlier header bytes yield nothing. Each payload byte then yields a payload
// result, unmasked with the frame's key and flagged on the last byte of the
// frame. A frame of length zero is reported by its header result alone, with
// last_of_frame set. Extended lengths are decoded as sent, without checks on
// shortest form or the top bit; opcodes pass through, reserved bits do not.
// Throughput is one byte per clock: all parsing is done in the cycle a byte
// is taken, and a single output register holds the result, so a new byte is
// taken whenever that register is empty or is being drained in the same
// clock. A stall on the result side therefore stalls the byte input.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  wsd_byte_if.sink    rx,
  wsd_result_if.source result
);
  import wsd_pkg::*;

  // Parser state.
  phase_t              phase, phase_next;
  logic [HCOUNT_W-1:0] hdr_count, hdr_count_next;
  logic [BYTE_W-1:0]   hdr0, hdr0_next;
  logic [BYTE_W-1:0]   hdr1, hdr1_next;
  logic [LEN_W-1:0]    len_acc, len_acc_next;
  logic [KEY_W-1:0]    key_word, key_word_next;
  logic [LEN_W-1:0]    frame_len, frame_len_next;
  logic [LEN_W-1:0]    remaining, remaining_next;

  // Output register.
  logic                out_valid;
  logic                out_kind;
  logic [BYTE_W-1:0]   out_payload;
  logic [OPCODE_W-1:0] out_opcode;
  logic                out_fin;
  logic                out_masked;
  logic [LEN_W-1:0]    out_length;
  logic                out_last;

  // Header decode of the byte being taken.
  logic                accept;
  logic [BYTE_W-1:0]   second_byte;
  logic [6:0]          len_code;
  logic [HCOUNT_W-1:0] ext_bytes;
  logic [HCOUNT_W-1:0] hdr_size;
  logic [HCOUNT_W-1:0] count_inc;
  logic [HCOUNT_W-1:0] ext_offset;
  logic                hdr_done;
  logic [LEN_W-1:0]    decoded_len;
  logic                payload_last;

  // Result of the byte being taken.
  logic                emit;
  logic                emit_kind;
  logic [BYTE_W-1:0]   emit_payload;
  logic                emit_masked;
  logic [LEN_W-1:0]    emit_length;
  logic                emit_last;

  assign rx.ready = !out_valid || result.ready;
  assign accept   = rx.valid && rx.ready;

  // Header size and completion, using the second byte as it will be stored.
  always_comb begin
    second_byte = (hdr_count == POS_SECOND) ? rx.rx_byte : hdr1;
    len_code    = second_byte[6:0];
    case (len_code)
      LEN_CODE_16: ext_bytes = EXT_BYTES_16;
      LEN_CODE_64: ext_bytes = EXT_BYTES_64;
      default:     ext_bytes = EXT_BYTES_NONE;
    endcase
    hdr_size     = BASE_HDR_BYTES + ext_bytes + (second_byte[7] ? KEY_BYTES : 4'd0);
    count_inc    = hdr_count + 4'd1;
    ext_offset   = hdr_count - BASE_HDR_BYTES;
    hdr_done     = (count_inc >= BASE_HDR_BYTES) && (count_inc >= hdr_size);
    payload_last = (remaining[LEN_W-1:1] == '0);
  end

  // Header field capture and length accumulation.
  always_comb begin
    hdr0_next    = hdr0;
    hdr1_next    = hdr1;
    len_acc_next = len_acc;
    if (hdr_count == POS_FIRST) begin
      hdr0_next = rx.rx_byte;
    end else if (hdr_count == POS_SECOND) begin
      hdr1_next    = rx.rx_byte;
      len_acc_next = '0;
    end else if (ext_offset < ext_bytes) begin
      len_acc_next = {len_acc[LEN_W-BYTE_W-1:0], rx.rx_byte};
    end
    if (ext_bytes == EXT_BYTES_NONE) begin
      decoded_len = {{(LEN_W-7){1'b0}}, len_code};
    end else begin
      decoded_len = len_acc_next;
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: begin
        if (hdr_done && (decoded_len != '0)) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_last) begin
          phase_next = PH_HEADER;
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  // Counters, key rotation and the result of the byte.
  always_comb begin
    hdr_count_next = hdr_count;
    key_word_next  = key_word;
    frame_len_next = frame_len;
    remaining_next = remaining;
    emit           = 1'b0;
    emit_kind      = KIND_HEADER;
    emit_payload   = '0;
    emit_masked    = hdr1[7];
    emit_length    = frame_len;
    emit_last      = 1'b0;
    case (phase)
      PH_HEADER: begin
        // Mask key bytes follow the extended length; the first lands on top.
        if ((hdr_count >= BASE_HDR_BYTES) && !(ext_offset < ext_bytes)) begin
          key_word_next = {key_word[KEY_W-BYTE_W-1:0], rx.rx_byte};
        end
        emit_masked = second_byte[7];
        emit_length = decoded_len;
        emit_last   = (decoded_len == '0);
        if (hdr_done) begin
          hdr_count_next = '0;
          frame_len_next = decoded_len;
          remaining_next = decoded_len;
          emit           = 1'b1;
        end else begin
          hdr_count_next = count_inc;
        end
      end
      PH_PAYLOAD: begin
        // Unmask with the top key byte, then rotate to the next one.
        emit         = 1'b1;
        emit_kind    = KIND_PAYLOAD;
        emit_payload = rx.rx_byte ^ (hdr1[7] ? key_word[KEY_W-1 -: BYTE_W] : '0);
        emit_last    = payload_last;
        key_word_next = {key_word[KEY_W-BYTE_W-1:0], key_word[KEY_W-1 -: BYTE_W]};
        if (payload_last) begin
          remaining_next = '0;
        end else begin
          remaining_next = remaining - 64'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_count <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        hdr_count <= hdr_count_next;
        remaining <= remaining_next;
        out_valid <= emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header fields, key and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (phase == PH_HEADER) begin
        hdr0    <= hdr0_next;
        hdr1    <= hdr1_next;
        len_acc <= len_acc_next;
      end
      key_word  <= key_word_next;
      frame_len <= frame_len_next;
      if (emit) begin
        out_kind    <= emit_kind;
        out_payload <= emit_payload;
        out_opcode  <= hdr0[OPCODE_W-1:0];
        out_fin     <= hdr0[7];
        out_masked  <= emit_masked;
        out_length  <= emit_length;
        out_last    <= emit_last;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.result_kind    = out_kind;
  assign result.payload_byte   = out_payload;
  assign result.frame_opcode   = out_opcode;
  assign result.final_fragment = out_fin;
  assign result.was_masked     = out_masked;
  assign result.frame_length   = out_length;
  assign result.last_of_frame  = out_last;

endmodule

`default_nettype wire

// ===== sim/websocket_frame_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends a byte stream of whole frames into the deframer: a few hand-built
// frames first (empty frame, extended lengths, the largest header), then
// random frames, and at the end a frame whose 64-bit length has every bit
// set. A model of the deframer in this file predicts every header and
// payload transaction, and a monitor compares them field by field. Both
// channels idle at random, and the result side once holds off for a long
// stretch so that the block stalls its byte input.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_unit_tb;
  import wsd_pkg::*;

  localparam int HDR_DEPTH    = 14;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 80;
  localparam int STREAM_BYTES = 740;
  localparam int MAX_PRINTED  = 30;

  // One header or payload transaction as the deframer should produce it.
  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] pbyte;
    logic [3:0]        opcode;
    logic              fin;
    logic              masked;
    logic [LEN_W-1:0]  length;
    logic              last;
  } deframe_result_t;

  logic clk;
  logic rst;

  wsd_byte_if   rx_ch ();
  wsd_result_if res_ch ();

  websocket_frame_deframer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  // Bytes waiting to be sent and results waiting to be seen.
  logic [BYTE_W-1:0] stream_q [$];
  deframe_result_t   deframed_q [$];

  int          error_count;
  int          bytes_sent;
  int unsigned stall_cycles;
  int          hold_left;
  logic        hold_done;
  wire         no_idle = (bytes_sent >= 200) && (bytes_sent < 350);

  // Model state of the deframer.
  logic [BYTE_W-1:0]   hdr_bytes [HDR_DEPTH];
  logic [HCOUNT_W-1:0] hdr_count;
  phase_t              rx_phase;
  logic [LEN_W-1:0]    bytes_left;
  logic [1:0]          key_idx;

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Number of extended length bytes that the stored header announces.
  function automatic logic [HCOUNT_W-1:0] ext_len_bytes();
    if (hdr_bytes[POS_SECOND][6:0] == LEN_CODE_16) begin
      return EXT_BYTES_16;
    end else if (hdr_bytes[POS_SECOND][6:0] == LEN_CODE_64) begin
      return EXT_BYTES_64;
    end
    return EXT_BYTES_NONE;
  endfunction

  // Payload length of the stored header, extended fields read big-endian.
  function automatic logic [LEN_W-1:0] frame_len();
    logic [LEN_W-1:0] v;
    int               n;
    v = '0;
    n = int'(ext_len_bytes());
    if (n == 0) begin
      return LEN_W'(hdr_bytes[POS_SECOND][6:0]);
    end
    for (int i = 0; i < n; i++) begin
      v = {v[LEN_W-BYTE_W-1:0], hdr_bytes[HCOUNT_W'(BASE_HDR_BYTES + i)]};
    end
    return v;
  endfunction

  function automatic deframe_result_t make_result(kind_t kind, logic [BYTE_W-1:0] pbyte,
                                                  logic last);
    deframe_result_t r;
    r.kind   = kind;
    r.pbyte  = pbyte;
    r.opcode = hdr_bytes[POS_FIRST][3:0];
    r.fin    = hdr_bytes[POS_FIRST][7];
    r.masked = hdr_bytes[POS_SECOND][7];
    r.length = frame_len();
    r.last   = last;
    return r;
  endfunction

  // Advances the model by one received byte and queues the result it causes.
  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    logic [HCOUNT_W-1:0] need;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   v;
    logic                last;
    if (rx_phase == PH_HEADER) begin
      if (hdr_count >= HDR_DEPTH) begin
        hdr_count = '0;
      end
      hdr_bytes[hdr_count] = b;
      hdr_count = hdr_count + 1'b1;
      if (hdr_count >= BASE_HDR_BYTES) begin
        need = BASE_HDR_BYTES + ext_len_bytes() + (hdr_bytes[POS_SECOND][7] ? KEY_BYTES : '0);
        if (hdr_count >= need) begin
          hdr_count = '0;
          len = frame_len();
          deframed_q.push_back(make_result(KIND_HEADER, '0, len == '0));
          // A frame of length zero is complete with its header.
          if (len != '0) begin
            rx_phase   = PH_PAYLOAD;
            bytes_left = len;
            key_idx    = '0;
          end
        end
      end
    end else begin
      last = (bytes_left <= 1);
      v    = b;
      if (hdr_bytes[POS_SECOND][7]) begin
        v = v ^ hdr_bytes[BASE_HDR_BYTES + ext_len_bytes() + key_idx];
      end
      deframed_q.push_back(make_result(KIND_PAYLOAD, v, last));
      if (bytes_left != '0) begin
        bytes_left = bytes_left - 1'b1;
      end
      key_idx = key_idx + 1'b1;
      if (last) begin
        rx_phase   = PH_HEADER;
        bytes_left = '0;
        key_idx    = '0;
      end
    end
  endfunction

  // Queues one frame: header, optional extended length and key, then payload.
  task automatic add_frame(input logic [BYTE_W-1:0] first, input logic masked,
                           input logic [6:0] code, input logic [LEN_W-1:0] ext_len,
                           input int unsigned n_payload);
    stream_q.push_back(first);
    stream_q.push_back({masked, code});
    if (code == LEN_CODE_16) begin
      stream_q.push_back(ext_len[15:8]);
      stream_q.push_back(ext_len[7:0]);
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) begin
        stream_q.push_back(ext_len[i*BYTE_W +: BYTE_W]);
      end
    end
    if (masked) begin
      repeat (KEY_BYTES) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    repeat (n_payload) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic report_mismatch(input string field, input logic [LEN_W-1:0] got,
                                 input logic [LEN_W-1:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
    error_count++;
  endtask

  // Byte driver; the model advances on every accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
      bytes_sent    <= 0;
      rx_phase      = PH_HEADER;
      hdr_count     = '0;
      bytes_left    = '0;
      key_idx       = '0;
      for (int i = 0; i < HDR_DEPTH; i++) begin
        hdr_bytes[i] = '0;
      end
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        deframe_byte(rx_ch.rx_byte);
        bytes_sent <= bytes_sent + 1;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (stream_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= stream_q.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!hold_done && bytes_sent >= 100) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    deframe_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected transaction, result_kind", LEN_W'(res_ch.result_kind),
                        '0);
      end else begin
        want = deframed_q.pop_front();
        if (res_ch.result_kind !== want.kind) begin
          report_mismatch("result_kind", LEN_W'(res_ch.result_kind), LEN_W'(want.kind));
        end
        if (res_ch.payload_byte !== want.pbyte) begin
          report_mismatch("payload_byte", LEN_W'(res_ch.payload_byte), LEN_W'(want.pbyte));
        end
        if (res_ch.frame_opcode !== want.opcode) begin
          report_mismatch("frame_opcode", LEN_W'(res_ch.frame_opcode), LEN_W'(want.opcode));
        end
        if (res_ch.final_fragment !== want.fin) begin
          report_mismatch("final_fragment", LEN_W'(res_ch.final_fragment), LEN_W'(want.fin));
        end
        if (res_ch.was_masked !== want.masked) begin
          report_mismatch("was_masked", LEN_W'(res_ch.was_masked), LEN_W'(want.masked));
        end
        if (res_ch.frame_length !== want.length) begin
          report_mismatch("frame_length", res_ch.frame_length, want.length);
        end
        if (res_ch.last_of_frame !== want.last) begin
          report_mismatch("last_of_frame", LEN_W'(res_ch.last_of_frame), LEN_W'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[websocket_frame_deframer_unit] ERROR");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned      sel;
    int unsigned      n;
    logic [6:0]       code;
    logic [LEN_W-1:0] len;
    rst           = 1'b1;
    error_count   = 0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;

    // Empty final text frame, unmasked.
    add_frame(8'h81, 1'b0, 7'd0, '0, 0);
    // Reserved bits and opcode 15, 16-bit length not in shortest form.
    add_frame(8'h7F, 1'b1, LEN_CODE_16, 64'd1, 1);
    // Largest header: 64-bit length plus mask key.
    add_frame(8'hF2, 1'b1, LEN_CODE_64, 64'd2, 2);
    // One-byte unmasked frame with a short length.
    add_frame(8'h09, 1'b0, 7'd1, '0, 1);

    // Random frames, mostly short so that many headers pass.
    while (stream_q.size() < STREAM_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        code = 7'($urandom_range(0, 12));
        len  = LEN_W'(code);
      end else if (sel < 57) begin
        code = 7'($urandom_range(100, 125));
        len  = LEN_W'(code);
      end else if (sel < 85) begin
        code = LEN_CODE_16;
        len  = (sel < 59) ? LEN_W'($urandom_range(256, 300)) : LEN_W'($urandom_range(0, 24));
      end else begin
        code = LEN_CODE_64;
        len  = LEN_W'($urandom_range(0, 24));
      end
      n = 32'(len);
      add_frame(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), code, len, n);
    end

    // Last frame: 64-bit length with every bit set, taken as given.
    add_frame(8'h82, 1'b0, LEN_CODE_64, '1, 6);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stream_q.size() != 0 || rx_ch.valid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[websocket_frame_deframer_unit] OK");
    end else begin
      $display("[websocket_frame_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
